[hdl/fplm_pkg.sv]
// fplm_pkg: shared codes and default sizes for the price level matcher
// no dependencies; imported by fifo_price_level_matcher_core
package fplm_pkg;

    // default sizes, overridable on the top level
    localparam int LEVEL_DEPTH_DEF = 16;
    localparam int QTY_BITS_DEF    = 32;
    localparam int OWNER_BITS_DEF  = 16;

    // fixed port widths
    localparam int OWNER_PORT_BITS = 16;
    localparam int ID_BITS         = 32;
    localparam int PRICE_BITS      = 32;
    localparam int QTY_PORT_BITS   = 32;
    localparam int VOL_BITS        = 36;

    typedef enum logic {
        FUNC_ADD   = 1'b0,
        FUNC_MATCH = 1'b1
    } func_t;

    typedef enum logic [1:0] {
        KIND_FILL     = 2'd0,
        KIND_SUMMARY  = 2'd1,
        KIND_ADD_OK   = 2'd2,
        KIND_ADD_FULL = 2'd3
    } kind_t;

endpackage

[hdl/fplm_fill_unit.sv]
// fplm_fill_unit: shared compare and subtract for one fill step
// takes min(offered, asked) and returns what is left on both sides; no dependencies
module fplm_fill_unit #(
    parameter int QTY_BITS = 32
) (
    input  logic [QTY_BITS-1:0] offered,
    input  logic [QTY_BITS-1:0] remaining,
    output logic [QTY_BITS-1:0] take,
    output logic                full,
    output logic [QTY_BITS-1:0] offered_left,
    output logic [QTY_BITS-1:0] remaining_left
);

    // resting order is used up when it offers no more than is still asked
    assign full           = (offered <= remaining);
    assign take           = full ? offered : remaining;
    assign offered_left   = offered - take;
    assign remaining_left = remaining - take;

endmodule

[hdl/fifo_price_level_matcher_core.sv]
// fifo_price_level_matcher_core: one price level kept as a queue of resting orders
// depends on fplm_pkg and fplm_fill_unit
//
// Input words (s_valid/s_ready) are either an add (s_func = 0) or a match
// (s_func = 1). Result words leave on m_valid/m_ready; m_last marks the final
// word of each input. The level price is written through cfg_wr_en/cfg_wr_data
// while the block is idle, a rule the user must keep, as the block does not
// enforce it; the price is reported in every result. An add passes through
// ST_ADD and gives one word, waiting there while the output register is full:
// accepted, or rejected when the queue already holds LEVEL_DEPTH orders.
// A match walks the queue oldest first, one entry a cycle while no fill word
// waits on the output register, through the single read port of the entry
// memory, and rewrites the kept entries in place at the same time, so one pass
// both fills and compacts: one fill word per touched order, then a summary word.
// s_ready is high only while the sequencer is idle; the next word is taken
// while the last result still sits in the output register.
// If the receiver stalls, the walk holds on the next entry that needs a fill
// word; entries that give no word pass without waiting.
// Reset empties the queue and clears the volume and the level price.
module fifo_price_level_matcher_core #(
    parameter int LEVEL_DEPTH = fplm_pkg::LEVEL_DEPTH_DEF,
    parameter int QTY_BITS    = fplm_pkg::QTY_BITS_DEF,
    parameter int OWNER_BITS  = fplm_pkg::OWNER_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,

    input  logic                                 cfg_wr_en,
    input  logic [fplm_pkg::PRICE_BITS-1:0]      cfg_wr_data,

    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_func,
    input  logic [fplm_pkg::OWNER_PORT_BITS-1:0] s_owner_id,
    input  logic [fplm_pkg::ID_BITS-1:0]         s_order_id,
    input  logic [fplm_pkg::QTY_PORT_BITS-1:0]   s_quantity,

    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [1:0]                           m_kind,
    output logic [fplm_pkg::OWNER_PORT_BITS-1:0] m_owner_id_res,
    output logic [fplm_pkg::ID_BITS-1:0]         m_order_id_res,
    output logic [fplm_pkg::PRICE_BITS-1:0]      m_price,
    output logic [fplm_pkg::QTY_PORT_BITS-1:0]   m_quantity_res,
    output logic                                 m_fill_full,
    output logic [fplm_pkg::VOL_BITS-1:0]        m_level_volume,
    output logic                                 m_last
);

    import fplm_pkg::*;

    localparam int OW = (OWNER_BITS < OWNER_PORT_BITS) ? OWNER_BITS : OWNER_PORT_BITS;
    localparam int QW = QTY_BITS;
    localparam int IW = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
    localparam int CW = $clog2(LEVEL_DEPTH + 1);
    localparam int EW = OW + ID_BITS + QW;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ADD,
        ST_WALK,
        ST_SUM
    } state_t;

    // entry memory: {owner, id, quantity}
    logic [EW-1:0] mem [LEVEL_DEPTH];
    logic          mem_we;
    logic [IW-1:0] mem_waddr;
    logic [EW-1:0] mem_wdata;
    logic          rd_en;
    logic [IW-1:0] rd_addr;
    logic [EW-1:0] rd_data_reg;

    state_t               state_reg, state_next;
    logic [PRICE_BITS-1:0] level_price_reg;
    logic [CW-1:0]        count_reg, count_next;
    logic [VOL_BITS-1:0]  total_reg, total_next;
    logic [OW-1:0]        owner_reg, owner_next;
    logic [ID_BITS-1:0]   id_reg, id_next;
    logic [QW-1:0]        rem_reg, rem_next;
    logic [QW-1:0]        alloc_reg, alloc_next;
    logic [IW-1:0]        idx_reg, idx_next;
    logic [CW-1:0]        wr_reg, wr_next;

    logic                       m_valid_reg, m_valid_next;
    kind_t                      m_kind_reg, m_kind_next;
    logic [OWNER_PORT_BITS-1:0] m_owner_reg, m_owner_next;
    logic [ID_BITS-1:0]         m_id_reg, m_id_next;
    logic [QTY_PORT_BITS-1:0]   m_qty_reg, m_qty_next;
    logic                       m_full_reg, m_full_next;
    logic [VOL_BITS-1:0]        m_vol_reg, m_vol_next;
    logic                       m_last_reg, m_last_next;

    logic [OW-1:0]      ent_owner;
    logic [ID_BITS-1:0] ent_id;
    logic [QW-1:0]      ent_qty;
    logic [QW-1:0]      fu_take;
    logic               fu_full;
    logic [QW-1:0]      fu_offered_left;
    logic [QW-1:0]      fu_remaining_left;
    logic               out_free;
    logic               engaged;
    logic               keep;
    logic               walk_end;

    assign ent_owner = rd_data_reg[EW-1 -: OW];
    assign ent_id    = rd_data_reg[QW +: ID_BITS];
    assign ent_qty   = rd_data_reg[QW-1:0];

    fplm_fill_unit #(
        .QTY_BITS (QW)
    ) u_fill (
        .offered        (ent_qty),
        .remaining      (rem_reg),
        .take           (fu_take),
        .full           (fu_full),
        .offered_left   (fu_offered_left),
        .remaining_left (fu_remaining_left)
    );

    assign out_free = !m_valid_reg || m_ready;
    assign engaged  = (rem_reg != '0) && (ent_owner != owner_reg);
    assign walk_end = ((CW'(idx_reg) + CW'(1)) == count_reg);
    assign s_ready  = (state_reg == ST_IDLE);

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        total_next   = total_reg;
        owner_next   = owner_reg;
        id_next      = id_reg;
        rem_next     = rem_reg;
        alloc_next   = alloc_reg;
        idx_next     = idx_reg;
        wr_next      = wr_reg;
        m_valid_next = m_valid_reg;
        m_kind_next  = m_kind_reg;
        m_owner_next = m_owner_reg;
        m_id_next    = m_id_reg;
        m_qty_next   = m_qty_reg;
        m_full_next  = m_full_reg;
        m_vol_next   = m_vol_reg;
        m_last_next  = m_last_reg;
        mem_we       = 1'b0;
        mem_waddr    = wr_reg[IW-1:0];
        mem_wdata    = rd_data_reg;
        rd_en        = 1'b0;
        rd_addr      = '0;
        keep         = 1'b1;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    owner_next = OW'(s_owner_id);
                    id_next    = s_order_id;
                    rem_next   = QW'(s_quantity);
                    alloc_next = '0;
                    idx_next   = '0;
                    wr_next    = '0;
                    if (s_func == FUNC_ADD) begin
                        state_next = ST_ADD;
                    end else if (count_reg == '0) begin
                        state_next = ST_SUM;
                    end else begin
                        // prefetch the oldest entry
                        rd_en      = 1'b1;
                        rd_addr    = '0;
                        state_next = ST_WALK;
                    end
                end
            end
            ST_ADD: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_owner_next = OWNER_PORT_BITS'(owner_reg);
                    m_id_next    = id_reg;
                    m_qty_next   = QTY_PORT_BITS'(rem_reg);
                    m_full_next  = 1'b0;
                    m_last_next  = 1'b1;
                    if (count_reg == CW'(LEVEL_DEPTH)) begin
                        m_kind_next = KIND_ADD_FULL;
                        m_vol_next  = total_reg;
                    end else begin
                        mem_we      = 1'b1;
                        mem_waddr   = count_reg[IW-1:0];
                        mem_wdata   = {owner_reg, id_reg, rem_reg};
                        count_next  = count_reg + CW'(1);
                        total_next  = total_reg + VOL_BITS'(rem_reg);
                        m_kind_next = KIND_ADD_OK;
                        m_vol_next  = total_next;
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_WALK: begin
                // a fill word needs the output register; other entries pass through
                if (!engaged || out_free) begin
                    if (engaged) begin
                        keep         = !fu_full;
                        rem_next     = fu_remaining_left;
                        alloc_next   = alloc_reg + fu_take;
                        total_next   = total_reg - VOL_BITS'(fu_take);
                        mem_wdata    = {ent_owner, ent_id, fu_offered_left};
                        m_valid_next = 1'b1;
                        m_kind_next  = KIND_FILL;
                        m_owner_next = OWNER_PORT_BITS'(ent_owner);
                        m_id_next    = ent_id;
                        m_qty_next   = QTY_PORT_BITS'(fu_take);
                        m_full_next  = fu_full;
                        m_vol_next   = total_next;
                        m_last_next  = 1'b0;
                    end
                    // kept entries slide down to the write pointer, never past the read one
                    mem_we  = keep;
                    wr_next = wr_reg + CW'(keep);
                    if (walk_end) begin
                        count_next = wr_next;
                        state_next = ST_SUM;
                    end else begin
                        idx_next = idx_reg + IW'(1);
                        rd_en    = 1'b1;
                        rd_addr  = idx_next;
                    end
                end
            end
            ST_SUM: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_kind_next  = KIND_SUMMARY;
                    m_owner_next = OWNER_PORT_BITS'(owner_reg);
                    m_id_next    = '0;
                    m_qty_next   = QTY_PORT_BITS'(alloc_reg);
                    m_full_next  = (rem_reg == '0);
                    m_vol_next   = total_reg;
                    m_last_next  = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            level_price_reg <= '0;
            count_reg       <= '0;
            total_reg       <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            total_reg   <= total_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                level_price_reg <= cfg_wr_data;
            end
        end
        owner_reg   <= owner_next;
        id_reg      <= id_next;
        rem_reg     <= rem_next;
        alloc_reg   <= alloc_next;
        idx_reg     <= idx_next;
        wr_reg      <= wr_next;
        m_kind_reg  <= m_kind_next;
        m_owner_reg <= m_owner_next;
        m_id_reg    <= m_id_next;
        m_qty_reg   <= m_qty_next;
        m_full_reg  <= m_full_next;
        m_vol_reg   <= m_vol_next;
        m_last_reg  <= m_last_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_kind         = m_kind_reg;
    assign m_owner_id_res = m_owner_reg;
    assign m_order_id_res = m_id_reg;
    assign m_price        = level_price_reg;
    assign m_quantity_res = m_qty_reg;
    assign m_fill_full    = m_full_reg;
    assign m_level_volume = m_vol_reg;
    assign m_last         = m_last_reg;

endmodule
